// ----- sv/mrfae_pkg.sv -----
// mrfae_pkg: operation codes, decoded-instruction and result types
// shared by the front, back and top level of the integer execute block
// no dependencies
package mrfae_pkg;

  localparam int NumRegs  = 32;
  localparam int RegAddrW = 5;
  localparam int DataW    = 32;
  localparam int ImmW     = 16;

  typedef enum logic [4:0] {
    ACT_ADD   = 5'd0,
    ACT_ADDU  = 5'd1,
    ACT_SUB   = 5'd2,
    ACT_SUBU  = 5'd3,
    ACT_AND   = 5'd4,
    ACT_OR    = 5'd5,
    ACT_XOR   = 5'd6,
    ACT_NOR   = 5'd7,
    ACT_SLT   = 5'd8,
    ACT_SLTU  = 5'd9,
    ACT_SLL   = 5'd10,
    ACT_SRL   = 5'd11,
    ACT_ADDI  = 5'd12,
    ACT_ADDIU = 5'd13,
    ACT_ANDI  = 5'd14,
    ACT_ORI   = 5'd15,
    ACT_XORI  = 5'd16,
    ACT_SLTI  = 5'd17,
    ACT_SLTIU = 5'd18,
    ACT_LUI   = 5'd19,
    ACT_BEQ   = 5'd20,
    ACT_BNE   = 5'd21,
    ACT_BLEZ  = 5'd22,
    ACT_BGTZ  = 5'd23,
    ACT_JR    = 5'd24
  } action_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_ALU    = 2'd1,
    CLS_BRANCH = 2'd2,
    CLS_JUMP   = 2'd3
  } class_e;

  typedef struct packed {
    action_e               op;
    class_e                cls;
    logic                  wr;     // writes a nonzero destination
    logic [RegAddrW-1:0]   dst;
    logic [RegAddrW-1:0]   rs;
    logic [RegAddrW-1:0]   rt;
    logic [4:0]            shamt;
    logic [ImmW-1:0]       imm;
  } decoded_t;

  typedef struct packed {
    logic                  wrote;
    logic [RegAddrW-1:0]   written_reg;
    logic [DataW-1:0]      written_value;
    logic                  branch_taken;
    logic [ImmW-1:0]       branch_offset;
    logic                  jump_valid;
    logic [DataW-1:0]      jump_target;
  } result_t;

endpackage

// ----- sv/mrfae_fifo.sv -----
// mrfae_fifo: small register-based queue with push/full and pop/empty sides
// generic, no package dependency; Depth must be at least 2
module mrfae_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/mrfae_front.sv -----
// mrfae_front: classifies incoming instructions and buffers them for the back end
// depends on mrfae_pkg and mrfae_fifo
module mrfae_front #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [4:0]        action_i,
  input  logic [4:0]        source_reg_i,
  input  logic [4:0]        target_reg_i,
  input  logic [4:0]        dest_reg_i,
  input  logic [4:0]        shift_amount_i,
  input  logic [15:0]       immediate_i,
  input  logic              pop_i,
  output logic              empty_o,
  output mrfae_pkg::decoded_t dec_o
);
  import mrfae_pkg::*;

  decoded_t                   dec;
  logic [$bits(decoded_t)-1:0] q_data;

  always_comb begin
    dec       = '0;
    dec.op    = action_e'(action_i);
    dec.rs    = source_reg_i;
    dec.rt    = target_reg_i;
    dec.shamt = shift_amount_i;
    dec.imm   = immediate_i;
    if (action_i inside {[ACT_ADD:ACT_SRL]}) begin
      // r-type writes rd
      dec.cls = CLS_ALU;
      dec.dst = dest_reg_i;
    end else if (action_i inside {[ACT_ADDI:ACT_LUI]}) begin
      // i-type writes rt
      dec.cls = CLS_ALU;
      dec.dst = target_reg_i;
    end else if (action_i inside {[ACT_BEQ:ACT_BGTZ]}) begin
      dec.cls = CLS_BRANCH;
    end else if (action_i == ACT_JR) begin
      dec.cls = CLS_JUMP;
    end else begin
      dec.cls = CLS_NONE;
    end
    // register zero is never written
    dec.wr = (dec.cls == CLS_ALU) && (dec.dst != '0);
    if (!dec.wr) begin
      dec.dst = '0;
    end
  end

  mrfae_fifo #(
    .Width ($bits(decoded_t)),
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (dec),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (q_data),
    .empty_o (empty_o)
  );

  assign dec_o = decoded_t'(q_data);

endmodule

// ----- sv/mrfae_back.sv -----
// mrfae_back: register file read, execute and write-back
// depends on mrfae_pkg
module mrfae_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                dq_empty_i,
  input  mrfae_pkg::decoded_t dq_data_i,
  output logic                dq_pop_o,
  output logic                res_push_o,
  output mrfae_pkg::result_t  res_data_o,
  input  logic                res_full_i
);
  import mrfae_pkg::*;

  logic [DataW-1:0]   rf_q [NumRegs];
  logic [NumRegs-1:0] rf_vld_q, rf_vld_d;

  logic               e_vld_q, e_vld_d;
  decoded_t           e_q;
  logic [DataW-1:0]   a_q, b_q;

  logic               e_fire, load, byp_a, byp_b;
  logic [DataW-1:0]   simm, zimm, val;
  logic               taken;
  result_t            res;

  assign e_fire   = e_vld_q && !res_full_i;
  assign load     = !dq_empty_i && (!e_vld_q || e_fire);
  assign dq_pop_o = load;
  assign e_vld_d  = load ? 1'b1 : (e_fire ? 1'b0 : e_vld_q);

  // write in the same edge as the read: take the new value
  assign byp_a = e_fire && e_q.wr && (e_q.dst == dq_data_i.rs);
  assign byp_b = e_fire && e_q.wr && (e_q.dst == dq_data_i.rt);

  assign simm = {{(DataW-ImmW){e_q.imm[ImmW-1]}}, e_q.imm};
  assign zimm = {{(DataW-ImmW){1'b0}}, e_q.imm};

  always_comb begin
    val   = '0;
    taken = 1'b0;
    case (e_q.op)
      ACT_ADD, ACT_ADDU:   val = a_q + b_q;
      ACT_SUB, ACT_SUBU:   val = a_q - b_q;
      ACT_AND:             val = a_q & b_q;
      ACT_OR:              val = a_q | b_q;
      ACT_XOR:             val = a_q ^ b_q;
      ACT_NOR:             val = ~(a_q | b_q);
      ACT_SLT:             val = DataW'($signed(a_q) < $signed(b_q));
      ACT_SLTU:            val = DataW'(a_q < b_q);
      ACT_SLL:             val = b_q << e_q.shamt;
      ACT_SRL:             val = b_q >> e_q.shamt;
      ACT_ADDI, ACT_ADDIU: val = a_q + simm;
      ACT_ANDI:            val = a_q & zimm;
      ACT_ORI:             val = a_q | zimm;
      ACT_XORI:            val = a_q ^ zimm;
      ACT_SLTI:            val = DataW'($signed(a_q) < $signed(simm));
      ACT_SLTIU:           val = DataW'(a_q < zimm);
      ACT_LUI:             val = {e_q.imm, {(DataW-ImmW){1'b0}}};
      ACT_BEQ:             taken = (a_q == b_q);
      ACT_BNE:             taken = (a_q != b_q);
      ACT_BLEZ:            taken = (a_q == '0) || a_q[DataW-1];
      ACT_BGTZ:            taken = (a_q != '0) && !a_q[DataW-1];
      default:             val = '0;
    endcase
  end

  always_comb begin
    res = '0;
    case (e_q.cls)
      CLS_ALU: begin
        res.wrote         = e_q.wr;
        res.written_reg   = e_q.dst;
        res.written_value = e_q.wr ? val : '0;
      end
      CLS_BRANCH: begin
        res.branch_taken  = taken;
        res.branch_offset = e_q.imm;
      end
      CLS_JUMP: begin
        res.jump_valid    = 1'b1;
        res.jump_target   = a_q;
      end
      default: res = '0;
    endcase
  end

  assign res_push_o = e_fire;
  assign res_data_o = res;

  always_comb begin
    rf_vld_d = rf_vld_q;
    if (e_fire && e_q.wr) begin
      rf_vld_d[e_q.dst] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q  <= 1'b0;
      rf_vld_q <= '0;
    end else begin
      e_vld_q  <= e_vld_d;
      rf_vld_q <= rf_vld_d;
    end
  end

  // register file array and registered read ports
  always_ff @(posedge clk_i) begin
    if (e_fire && e_q.wr) begin
      rf_q[e_q.dst] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      e_q <= dq_data_i;
      a_q <= byp_a ? val : (rf_vld_q[dq_data_i.rs] ? rf_q[dq_data_i.rs] : '0);
      b_q <= byp_b ? val : (rf_vld_q[dq_data_i.rt] ? rf_q[dq_data_i.rt] : '0);
    end
  end

endmodule

// ----- sv/mips_register_file_alu_execute_top.sv -----
// integer execute block: front decode queue, register-file/execute back end, result queue
// path: a beat is held in the decode queue, then in the execute register, then in the result
// queue, where it shows on the result ports and can be popped when nothing stalls
// throughput: one instruction per cycle while the result queue is not full, bounded by the single execute stage
// reset: asynchronous active low; queues empty, all 32 registers read as zero after reset
// depends on mrfae_pkg, mrfae_front, mrfae_back, mrfae_fifo
module mips_register_file_alu_execute_top #(
  parameter int DecDepth = 2,
  parameter int ResDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // instruction side
  input  logic               push,
  output logic               full,
  input  logic [4:0]         action_i,
  input  logic [4:0]         source_reg_i,
  input  logic [4:0]         target_reg_i,
  input  logic [4:0]         dest_reg_i,
  input  logic [4:0]         shift_amount_i,
  input  logic [15:0]        immediate_i,
  // result side
  output logic               empty,
  input  logic               pop,
  output logic               wrote_o,
  output logic [4:0]         written_reg_o,
  output logic [31:0]        written_value_o,
  output logic               branch_taken_o,
  output logic signed [15:0] branch_offset_o,
  output logic               jump_valid_o,
  output logic [31:0]        jump_target_o
);
  import mrfae_pkg::*;

  // front to back: classified instructions
  decoded_t                   dq_data;
  logic                       dq_empty;
  logic                       dq_pop;

  // back to result queue
  result_t                    res_data;
  logic                       res_push;
  logic                       res_full;
  logic [$bits(result_t)-1:0] out_data;
  result_t                    out_res;

  // front: decode the beat and hold it until the back end is free
  mrfae_front #(
    .Depth (DecDepth)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .action_i       (action_i),
    .source_reg_i   (source_reg_i),
    .target_reg_i   (target_reg_i),
    .dest_reg_i     (dest_reg_i),
    .shift_amount_i (shift_amount_i),
    .immediate_i    (immediate_i),
    .pop_i          (dq_pop),
    .empty_o        (dq_empty),
    .dec_o          (dq_data)
  );

  // back: read operands with write bypass, execute, write back
  mrfae_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .dq_empty_i (dq_empty),
    .dq_data_i  (dq_data),
    .dq_pop_o   (dq_pop),
    .res_push_o (res_push),
    .res_data_o (res_data),
    .res_full_i (res_full)
  );

  // result queue decouples the execute stage from the consumer
  mrfae_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data),
    .empty_o (empty)
  );

  assign out_res         = result_t'(out_data);
  assign wrote_o         = out_res.wrote;
  assign written_reg_o   = out_res.written_reg;
  assign written_value_o = out_res.written_value;
  assign branch_taken_o  = out_res.branch_taken;
  assign branch_offset_o = $signed(out_res.branch_offset);
  assign jump_valid_o    = out_res.jump_valid;
  assign jump_target_o   = out_res.jump_target;

endmodule
